/* rtl/gbts_pkg.sv */
// shared types and constants for the gap buffer text store
package gbts_pkg;

    // storage geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = ADDR_W + 1;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BKSP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_SEL = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // command transaction
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_in;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  end_position;
    } t_item;

    // result transaction
    typedef struct packed {
        logic [CHAR_W-1:0]   char_out;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    text_length;
        logic [POS_W-1:0]    cursor;
    } t_result;

    // sequencer to output stage
    typedef struct packed {
        logic    valid;
        t_result result;
    } t_done;

    // sequencer to byte store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

/* rtl/gap_buffer_text_store.sv */
// Gap buffer text store, capacity 1024 bytes, one result per command transaction.
// Insert and error cases go from decode straight to done; backspace, delete-after and
// read add a read-data state; move alternates shift fetch and write per byte shifted, and
// selection delete shifts the same way, then widens the gap and reads when bytes are removed.
// One command at a time: busy drops with the strobe, so the next is taken
// at the edge that ends the strobe cycle. Synchronous active-low reset
// empties the text; the receiver cannot stall.
module gap_buffer_text_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gbts_pkg::t_item   i_item,
    output logic              o_busy,
    output logic              o_valid,
    output gbts_pkg::t_result o_result
);
    import gbts_pkg::*;

    t_ram_req          ram_req;
    t_done             done;
    logic [CHAR_W-1:0] rdata;

    gbts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_rdata (rdata),
        .o_busy  (o_busy),
        .o_req   (ram_req),
        .o_done  (done)
    );

    gbts_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= done.valid;
        end
        if (done.valid) begin
            o_result <= done.result;
        end
    end

endmodule

/* rtl/gbts_ram.sv */
// byte store: one write port, one registered read port
module gbts_ram (
    input  logic              i_clk,
    input  gbts_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import gbts_pkg::*;

    logic [CHAR_W-1:0] r_mem [CAPACITY];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

/* rtl/gbts_seq.sv */
// command sequencer: gap pointers and byte-at-a-time shift engine
module gbts_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  gbts_pkg::t_item    i_item,
    input  logic [7:0]         i_rdata,
    output logic               o_busy,
    output gbts_pkg::t_ram_req o_req,
    output gbts_pkg::t_done    o_done
);
    import gbts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_SHWR,
        S_SELDEL,
        S_RDATA,
        S_DONE
    } t_state;

    localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_gs, n_gs;
    logic [PTR_W-1:0]   r_ge, n_ge;
    t_item              r_item, n_item;
    logic [CHAR_W-1:0]  r_byte, n_byte;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [PTR_W-1:0]   r_target, n_target;
    logic [PTR_W-1:0]   r_count, n_count;
    logic               r_left, n_left;

    logic [PTR_W-1:0]   len;
    logic [PTR_W-1:0]   gap;
    logic [PTR_W-1:0]   gs_m1;
    logic [PTR_W-1:0]   ge_m1;
    logic [PTR_W-1:0]   rd_idx;
    logic [PTR_W-1:0]   sel_last;
    logic [PTR_W-1:0]   pos;
    logic [PTR_W-1:0]   endp;

    // pointer arithmetic
    assign gap      = r_ge - r_gs;
    assign len      = CAP_P - gap;
    assign gs_m1    = r_gs - 1'b1;
    assign ge_m1    = r_ge - 1'b1;
    assign pos      = PTR_W'(r_item.position);
    assign endp     = PTR_W'(r_item.end_position);
    assign rd_idx   = (pos >= r_gs) ? (pos + gap) : pos;
    assign sel_last = r_ge + r_count - 1'b1;

    assign o_busy = (r_state != S_IDLE);

    // next-state and datapath control
    always_comb begin
        n_state  = r_state;
        n_gs     = r_gs;
        n_ge     = r_ge;
        n_item   = r_item;
        n_byte   = r_byte;
        n_status = r_status;
        n_target = r_target;
        n_count  = r_count;
        n_left   = r_left;
        o_req    = '0;
        o_done.valid              = 1'b0;
        o_done.result.char_out    = r_byte;
        o_done.result.status      = r_status;
        o_done.result.text_length = LEN_W'(len);
        o_done.result.cursor      = POS_W'(r_gs);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_byte   = '0;
                n_status = ST_OK;
                n_state  = S_DONE;
                case (r_item.cmd)
                    CMD_INSERT: begin
                        if (r_gs == r_ge) begin
                            n_status = ST_FULL;
                        end else begin
                            o_req.we    = 1'b1;
                            o_req.waddr = r_gs[ADDR_W-1:0];
                            o_req.wdata = r_item.char_in;
                            n_gs        = r_gs + 1'b1;
                        end
                    end
                    CMD_MOVE: begin
                        if (pos > len) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_target = pos;
                            n_state  = S_SHIFT;
                        end
                    end
                    CMD_BKSP: begin
                        if (r_gs == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_req.re    = 1'b1;
                            o_req.raddr = gs_m1[ADDR_W-1:0];
                            n_gs        = gs_m1;
                            n_state     = S_RDATA;
                        end
                    end
                    CMD_DEL: begin
                        if (r_ge >= CAP_P) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_req.re    = 1'b1;
                            o_req.raddr = r_ge[ADDR_W-1:0];
                            n_ge        = r_ge + 1'b1;
                            n_state     = S_RDATA;
                        end
                    end
                    CMD_READ: begin
                        if (pos >= len) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_req.re    = 1'b1;
                            o_req.raddr = rd_idx[ADDR_W-1:0];
                            n_state     = S_RDATA;
                        end
                    end
                    CMD_DEL_SEL: begin
                        if (pos > len || endp > len || pos > endp) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_target = pos;
                            n_count  = endp - pos;
                            n_state  = S_SHIFT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // fetch the next byte to carry across the gap
            S_SHIFT: begin
                if (r_gs > r_target) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = gs_m1[ADDR_W-1:0];
                    n_left      = 1'b1;
                    n_state     = S_SHWR;
                end else if (r_gs < r_target) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_ge[ADDR_W-1:0];
                    n_left      = 1'b0;
                    n_state     = S_SHWR;
                end else if (r_item.cmd == CMD_DEL_SEL) begin
                    n_state = S_SELDEL;
                end else begin
                    n_state = S_DONE;
                end
            end
            // store it on the other side and slide the gap
            S_SHWR: begin
                o_req.we    = 1'b1;
                o_req.wdata = i_rdata;
                if (r_left) begin
                    o_req.waddr = ge_m1[ADDR_W-1:0];
                    n_gs        = gs_m1;
                    n_ge        = ge_m1;
                end else begin
                    o_req.waddr = r_gs[ADDR_W-1:0];
                    n_gs        = r_gs + 1'b1;
                    n_ge        = r_ge + 1'b1;
                end
                n_state = S_SHIFT;
            end
            // widen the gap over a non-empty selection, fetch its last byte
            S_SELDEL: begin
                if (r_count != '0) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = sel_last[ADDR_W-1:0];
                    n_ge        = r_ge + r_count;
                    n_state     = S_RDATA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDATA: begin
                n_byte  = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done.valid = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= '0;
            r_ge    <= CAP_P;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
        end
        r_item   <= n_item;
        r_byte   <= n_byte;
        r_status <= n_status;
        r_target <= n_target;
        r_count  <= n_count;
        r_left   <= n_left;
    end

    // gap stays well formed
    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gs <= r_ge)
        else $error("gap start passed gap end");

    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ge <= CAP_P)
        else $error("gap end beyond capacity");

    // a shift step keeps the gap width
    a_shift_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |=> ((r_ge - r_gs) == $past(r_ge - r_gs)))
        else $error("shift step changed gap width");

    // a full report only when the gap is closed
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done.valid && o_done.result.status == ST_FULL) |-> (r_gs == r_ge))
        else $error("full status with open gap");

    // a move ends with the cursor on its target
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done.valid && r_item.cmd == CMD_MOVE && o_done.result.status == ST_OK)
        |-> (r_gs == r_target))
        else $error("cursor move missed target");

endmodule

/* test/tb_top.sv */
// testbench for the gap buffer text store: directed edges, a full buffer, random edit phases
`timescale 1ns / 100ps

module tb_top;
    import gbts_pkg::*;

    // encodings the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int DRAIN_LIMIT = 8192;
    localparam int TAIL_CYCLES = 16;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_item   i_item  = '0;
    logic    o_busy;
    logic    o_valid;
    t_result o_result;

    // mirror of the text: bytes below gap_lo, then bytes from gap_hi up
    logic [CHAR_W-1:0] text_mirror [CAPACITY];
    int gap_lo = 0;
    int gap_hi = CAPACITY;

    t_result pending_results[$];
    int sender_idle_pct = 0;
    int fail_count      = 0;
    int cmds_sent       = 0;
    int results_checked = 0;
    int peak_length     = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    gap_buffer_text_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int mirror_len();
        return CAPACITY - (gap_hi - gap_lo);
    endfunction

    // move the gap one byte at a time until it starts at target
    function automatic void slide_gap(input int target);
        while (gap_lo > target) begin
            gap_lo--;
            gap_hi--;
            text_mirror[gap_hi] = text_mirror[gap_lo];
        end
        while (gap_lo < target) begin
            text_mirror[gap_lo] = text_mirror[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    // apply one command to the mirror and return the result it should give
    function automatic t_result apply_edit(input t_item it);
        t_result r;
        int len, pos, endp, idx;
        r = '0;
        r.status = ST_OK;
        len  = mirror_len();
        pos  = int'(it.position);
        endp = int'(it.end_position);
        case (it.cmd)
            CMD_INSERT: begin
                if (gap_lo >= gap_hi) begin
                    r.status = ST_FULL;
                end else begin
                    text_mirror[gap_lo] = it.char_in;
                    gap_lo++;
                end
            end
            CMD_MOVE: begin
                if (pos > len) r.status = ST_RANGE;
                else slide_gap(pos);
            end
            CMD_BKSP: begin
                if (gap_lo == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    gap_lo--;
                    r.char_out = text_mirror[gap_lo];
                end
            end
            CMD_DEL: begin
                if (gap_hi >= CAPACITY) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.char_out = text_mirror[gap_hi];
                    gap_hi++;
                end
            end
            CMD_READ: begin
                if (pos >= len) begin
                    r.status = ST_RANGE;
                end else begin
                    idx = pos;
                    if (idx >= gap_lo) idx += gap_hi - gap_lo;
                    r.char_out = text_mirror[idx];
                end
            end
            CMD_DEL_SEL: begin
                if (pos > len || endp > len || pos > endp) begin
                    r.status = ST_RANGE;
                end else begin
                    slide_gap(pos);
                    // empty selection only moves the cursor
                    if (endp > pos) begin
                        gap_hi += endp - pos;
                        r.char_out = text_mirror[gap_hi - 1];
                    end
                end
            end
            default: ;
        endcase
        r.text_length = LEN_W'(mirror_len());
        r.cursor      = POS_W'(gap_lo);
        status_hits[r.status]++;
        if (mirror_len() > peak_length) peak_length = mirror_len();
        return r;
    endfunction

    function automatic t_item make_cmd(input logic [CMD_W-1:0] cmd, input int ch,
                                       input int pos, input int endp);
        t_item it;
        it.cmd          = cmd;
        it.char_in      = CHAR_W'(ch);
        it.position     = POS_W'(pos);
        it.end_position = POS_W'(endp);
        return it;
    endfunction

    // mostly legal edits on the current text, some out of range, a few arbitrary
    function automatic t_item random_cmd();
        t_item it;
        int len, roll, start, span;
        len  = mirror_len();
        it   = make_cmd(CMD_READ, $urandom_range(255), $urandom_range(len),
                        $urandom_range(POS_MAX));
        roll = $urandom_range(99);
        if (roll < 5) begin
            it.cmd          = CMD_W'($urandom_range(7));
            it.position     = POS_W'($urandom_range(POS_MAX));
            it.end_position = POS_W'($urandom_range(POS_MAX));
        end else if (roll < (len > 200 ? 15 : 42)) begin
            it.cmd = CMD_INSERT;
        end else begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                it.cmd = CMD_MOVE;
                if ($urandom_range(9) == 0)
                    it.position = POS_W'($urandom_range(POS_MAX, len + 1));
            end else if (roll < 38) begin
                it.cmd = CMD_BKSP;
            end else if (roll < 56) begin
                it.cmd = CMD_DEL;
            end else if (roll < 80) begin
                if (len > 0) it.position = POS_W'($urandom_range(len - 1));
                if ($urandom_range(9) == 0) it.position = POS_W'($urandom_range(POS_MAX, len));
            end else begin
                it.cmd = CMD_DEL_SEL;
                if ($urandom_range(9) == 0) begin
                    it.position = POS_W'($urandom_range(POS_MAX));
                end else begin
                    start = $urandom_range(len);
                    span  = (len - start < 24) ? len - start : 24;
                    it.position     = POS_W'(start);
                    it.end_position = POS_W'(start + $urandom_range(span));
                end
            end
        end
        return it;
    endfunction

    // present one command and wait for it to be taken
    task automatic issue_cmd(input t_item it);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(apply_edit(it));
        cmds_sent++;
    endtask

    // stop sending and let every outstanding result arrive
    task automatic drain_results();
        int waited;
        i_start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
            pending_results.delete();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each strobed result with the oldest expectation
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: cursor %0d", o_result.cursor);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("char_out", 16'(want.char_out), 16'(o_result.char_out));
                check_field("status", 16'(want.status), 16'(o_result.status));
                check_field("text_length", 16'(want.text_length),
                            16'(o_result.text_length));
                check_field("cursor", 16'(want.cursor), 16'(o_result.cursor));
                results_checked++;
            end
        end
    end

    // empty text, every command, bounds on either side of the text
    task automatic test_edge_cases();
        sender_idle_pct = 0;
        issue_cmd(make_cmd(CMD_BKSP, 0, 0, 0));
        issue_cmd(make_cmd(CMD_DEL, 0, 0, 0));
        issue_cmd(make_cmd(CMD_READ, 0, 0, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, 1, 0));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, 0));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, 1));
        issue_cmd(make_cmd(CMD_SPARE_A, 8'hff, POS_MAX, POS_MAX));
        issue_cmd(make_cmd(CMD_SPARE_B, 8'h81, 5, 3));
        issue_cmd(make_cmd(CMD_INSERT, 8'h00, 0, 0));
        issue_cmd(make_cmd(CMD_INSERT, 8'hff, POS_MAX, POS_MAX));
        issue_cmd(make_cmd(CMD_INSERT, 8'h5a, 0, 0));
        issue_cmd(make_cmd(CMD_INSERT, 8'ha5, 0, 0));
        issue_cmd(make_cmd(CMD_READ, 0, 0, 0));
        issue_cmd(make_cmd(CMD_READ, 0, 3, 0));
        issue_cmd(make_cmd(CMD_READ, 0, 4, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, 0, 0));
        issue_cmd(make_cmd(CMD_BKSP, 0, 0, 0));
        issue_cmd(make_cmd(CMD_DEL, 0, 0, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, 3, 0));
        issue_cmd(make_cmd(CMD_DEL, 0, 0, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, 4, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, POS_MAX, 0));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 2, 1));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, 4));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 1, 1));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, 2));
        issue_cmd(make_cmd(CMD_READ, 0, 0, 0));
        drain_results();
    endtask

    // fill to capacity with the gap moved to a random point at half full, then long moves and a full clear
    task automatic test_full_buffer();
        sender_idle_pct = 6;
        issue_cmd(make_cmd(CMD_MOVE, 0, 0, 0));
        while (mirror_len() < CAPACITY) begin
            if (mirror_len() == CAPACITY / 2)
                issue_cmd(make_cmd(CMD_MOVE, 0, $urandom_range(mirror_len()), 0));
            issue_cmd(make_cmd(CMD_INSERT, $urandom_range(255), 0, 0));
        end
        issue_cmd(make_cmd(CMD_INSERT, 8'h3c, 0, 0));
        issue_cmd(make_cmd(CMD_READ, 0, CAPACITY - 1, 0));
        issue_cmd(make_cmd(CMD_READ, 0, CAPACITY, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, CAPACITY, 0));
        issue_cmd(make_cmd(CMD_DEL, 0, 0, 0));
        issue_cmd(make_cmd(CMD_INSERT, 8'hc3, 0, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, CAPACITY + 1, 0));
        issue_cmd(make_cmd(CMD_MOVE, 0, 0, 0));
        issue_cmd(make_cmd(CMD_READ, 0, 0, 0));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, CAPACITY + 1));
        issue_cmd(make_cmd(CMD_DEL_SEL, 0, 0, CAPACITY));
        drain_results();
    endtask

    task automatic test_random_edits(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count) issue_cmd(random_cmd());
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_full_buffer();
        test_random_edits(130, 0);
        test_random_edits(130, 50);
        test_random_edits(130, 6);
        $display("%0d commands sent, %0d results checked, peak text length %0d",
                 cmds_sent, results_checked, peak_length);
        $display("outcomes: ok %0d, full %0d, nothing to remove %0d, out of range %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_RANGE]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("run timed out with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gbts_pkg.sv
rtl/gbts_ram.sv
rtl/gbts_seq.sv
rtl/gap_buffer_text_store.sv
test/tb_top.sv
